// ----- src/gbn_pkg.sv -----
package gbn_pkg;

  localparam int unsigned SEQ_W      = 32;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned WIN_W      = 16;
  localparam int unsigned FREED_W    = 6;
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [WIN_W-1:0] WINDOW_RESET    = 16'd40000;
  localparam logic [SEQ_W-1:0] START_SEQ_RESET = 32'd0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ    = 1'b1;

  typedef enum logic [CMD_W-1:0] {
    CMD_OFFER   = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_SEND      = 3'd0,
    KIND_REFUSED   = 3'd1,
    KIND_ACK_OK    = 3'd2,
    KIND_ACK_IGNORE = 3'd3,
    KIND_RETX      = 3'd4
  } kind_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [LEN_W-1:0] seg_len;
    logic [SEQ_W-1:0] ack_num;
  } in_t;

  typedef struct packed {
    kind_e              kind;
    logic [SEQ_W-1:0]   seq_out;
    logic [LEN_W-1:0]   len_out;
    logic [SEQ_W-1:0]   acked_to;
    logic [FREED_W-1:0] freed;
    logic               last;
  } out_t;

  // microprogram steps
  typedef enum logic [2:0] {
    S_IDLE     = 3'd0,
    S_OFFER    = 3'd1,
    S_ACK_SUB  = 3'd2,
    S_ACK_CHK  = 3'd3,
    S_ACK_LOOP = 3'd4,
    S_TO_INIT  = 3'd5,
    S_TO_LOOP  = 3'd6
  } step_e;

  // datapath operations driven by the control word
  typedef enum logic [2:0] {
    OP_NOP      = 3'd0,
    OP_OFFER    = 3'd1,
    OP_ACK_SUB  = 3'd2,
    OP_ACK_CHK  = 3'd3,
    OP_ACK_FREE = 3'd4,
    OP_TO_INIT  = 3'd5,
    OP_TO_EMIT  = 3'd6
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    J_NEVER     = 3'd0,
    J_ALWAYS    = 3'd1,
    J_DISPATCH  = 3'd2,
    J_ACK_BAD   = 3'd3,
    J_FREE_DONE = 3'd4,
    J_Q_EMPTY   = 3'd5,
    J_LAST      = 3'd6
  } jcond_e;

  typedef struct packed {
    op_e    op;
    jcond_e cond;
    step_e  target;
    step_e  next;
  } ctrl_t;

  typedef struct packed {
    logic ack_bad;
    logic free_done;
    logic q_empty;
    logic last_iter;
  } cond_t;

  // control store
  function automatic ctrl_t ucode(step_e s);
    ctrl_t w;
    case (s)
      S_IDLE:     w = '{OP_NOP,      J_DISPATCH,  S_IDLE, S_IDLE};
      S_OFFER:    w = '{OP_OFFER,    J_ALWAYS,    S_IDLE, S_IDLE};
      S_ACK_SUB:  w = '{OP_ACK_SUB,  J_NEVER,     S_IDLE, S_ACK_CHK};
      S_ACK_CHK:  w = '{OP_ACK_CHK,  J_ACK_BAD,   S_IDLE, S_ACK_LOOP};
      S_ACK_LOOP: w = '{OP_ACK_FREE, J_FREE_DONE, S_IDLE, S_ACK_LOOP};
      S_TO_INIT:  w = '{OP_TO_INIT,  J_Q_EMPTY,   S_IDLE, S_TO_LOOP};
      S_TO_LOOP:  w = '{OP_TO_EMIT,  J_LAST,      S_IDLE, S_TO_LOOP};
      default:    w = '{OP_NOP,      J_ALWAYS,    S_IDLE, S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// ----- src/gbn_ram.sv -----
module gbn_ram #(
  parameter int unsigned WIDTH = 11,
  parameter int unsigned DEPTH = 32,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/gbn_seq.sv -----
module gbn_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [gbn_pkg::CMD_W-1:0]  cmd_i,
  input  gbn_pkg::cond_t             cond_i,
  output gbn_pkg::op_e               op_o,
  output logic                       busy_o
);

  gbn_pkg::step_e step_q, step_d;
  gbn_pkg::ctrl_t ctrl;
  logic           take;

  assign ctrl = gbn_pkg::ucode(step_q);

  // next step
  always_comb begin
    take = 1'b0;
    step_d = ctrl.next;
    case (ctrl.cond)
      gbn_pkg::J_NEVER:     take = 1'b0;
      gbn_pkg::J_ALWAYS:    take = 1'b1;
      gbn_pkg::J_ACK_BAD:   take = cond_i.ack_bad;
      gbn_pkg::J_FREE_DONE: take = cond_i.free_done;
      gbn_pkg::J_Q_EMPTY:   take = cond_i.q_empty;
      gbn_pkg::J_LAST:      take = cond_i.last_iter;
      gbn_pkg::J_DISPATCH: begin
        if (start_i) begin
          case (cmd_i)
            gbn_pkg::CMD_OFFER:   step_d = gbn_pkg::S_OFFER;
            gbn_pkg::CMD_ACK:     step_d = gbn_pkg::S_ACK_SUB;
            gbn_pkg::CMD_TIMEOUT: step_d = gbn_pkg::S_TO_INIT;
            default:              step_d = gbn_pkg::S_IDLE;
          endcase
        end
      end
      default:              take = 1'b1;
    endcase
    if (take) begin
      step_d = ctrl.target;
    end
  end

  // outputs
  always_comb begin
    op_o   = ctrl.op;
    busy_o = (step_q != gbn_pkg::S_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= gbn_pkg::S_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

// ----- src/go_back_n_sender_window_core.sv -----
// channel   direction  handshake                   payload
// command   in         start_i && !busy_o          req_i (in_t: cmd, seg_len, ack_num)
// result    out        res_strobe_o, one cycle     res_o (out_t)
// config    in         cfg_valid_i && cfg_ready_o  cfg_index_i, cfg_data_i
//
// an offer holds busy for its S_OFFER step, then the next command can be accepted
// an ack: SUB, CHK, then LOOP, one queue read per freed segment; ignored ends at CHK
// a timeout: TO_INIT, a TO_LOOP result per queued segment, on consecutive cycles
// the single read port of the length queue sets the per-segment pace
// reset clears both edges to the start sequence and empties the queue
// results cannot be stalled; each is shown for exactly one cycle
module go_back_n_sender_window_core #(
  parameter int unsigned QUEUE_DEPTH = 32,
  parameter int unsigned MAX_SEG     = 2000
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  gbn_pkg::in_t                       req_i,
  output logic                               res_strobe_o,
  output gbn_pkg::out_t                      res_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gbn_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SW = gbn_pkg::SEQ_W;
  localparam int unsigned LW = gbn_pkg::LEN_W;

  // connection state
  logic [SW-1:0]                ack_edge_q, ack_edge_d;
  logic [SW-1:0]                send_edge_q, send_edge_d;
  logic [AW-1:0]                head_q, head_d;
  logic [CW-1:0]                count_q, count_d;
  logic [gbn_pkg::WIN_W-1:0]    window_q, window_d;
  logic [SW-1:0]                start_seq_q, start_seq_d;

  // working registers of the sequencer datapath
  logic [SW-1:0]                dist_q, dist_d;
  logic [SW-1:0]                span_q, span_d;
  logic [AW-1:0]                ptr_q, ptr_d;
  logic [CW-1:0]                iter_q, iter_d;
  logic [SW-1:0]                seq_q, seq_d;
  logic [CW-1:0]                freed_q, freed_d;
  gbn_pkg::in_t                 req_q, req_d;

  // result register
  gbn_pkg::out_t                res_q, res_d;
  logic                         strobe_q, strobe_d;

  // length queue port
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  logic [LW-1:0]                ram_rdata;

  gbn_pkg::op_e                 op;
  gbn_pkg::cond_t               cond;
  logic                         accept;

  logic [AW-1:0]                head_inc;
  logic [AW-1:0]                ptr_inc;
  logic [CW:0]                  wsum;
  logic [CW:0]                  wsum_wrap;
  logic [SW-1:0]                inflight;
  logic [SW-1:0]                rd_len;
  logic                         offer_ok;
  logic [CW+gbn_pkg::FREED_W-1:0] freed_wide;

  assign accept      = start_i && !busy_o;
  assign cfg_ready_o = 1'b1;

  gbn_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .cmd_i  (req_i.cmd),
    .cond_i (cond),
    .op_o   (op),
    .busy_o (busy_o)
  );

  gbn_ram #(
    .WIDTH(LW),
    .DEPTH(QUEUE_DEPTH)
  ) u_len_queue (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(req_q.seg_len),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // circular pointer steps
  assign head_inc = (head_q == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q + AW'(1);
  assign ptr_inc  = (ptr_q  == AW'(QUEUE_DEPTH - 1)) ? '0 : ptr_q  + AW'(1);

  // tail slot: head + count stays below twice the depth, one subtract wraps it
  assign wsum      = {{(CW + 1 - AW){1'b0}}, head_q} + {1'b0, count_q};
  assign wsum_wrap = (wsum >= (CW + 1)'(QUEUE_DEPTH)) ? wsum - (CW + 1)'(QUEUE_DEPTH) : wsum;
  assign ram_waddr = wsum_wrap[AW-1:0];

  assign inflight = send_edge_q - ack_edge_q;
  assign rd_len   = {{(SW - LW){1'b0}}, ram_rdata};

  assign offer_ok = (req_q.seg_len != '0) &&
                    (req_q.seg_len <= LW'(MAX_SEG)) &&
                    (inflight < {{(SW - gbn_pkg::WIN_W){1'b0}}, window_q}) &&
                    (count_q < CW'(QUEUE_DEPTH));

  assign freed_wide = {{gbn_pkg::FREED_W{1'b0}}, freed_q};

  // branch conditions seen by the sequencer
  always_comb begin
    cond.ack_bad   = (dist_q == '0) || (dist_q > span_q);
    cond.free_done = (count_q == '0) || (rd_len > dist_q);
    cond.q_empty   = (count_q == '0);
    cond.last_iter = (iter_q == CW'(1));
  end

  // datapath under the control word
  always_comb begin
    ack_edge_d  = ack_edge_q;
    send_edge_d = send_edge_q;
    head_d      = head_q;
    count_d     = count_q;
    window_d    = window_q;
    start_seq_d = start_seq_q;
    dist_d      = dist_q;
    span_d      = span_q;
    ptr_d       = ptr_q;
    iter_d      = iter_q;
    seq_d       = seq_q;
    freed_d     = freed_q;
    req_d       = req_q;
    res_d       = res_q;
    strobe_d    = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = head_q;

    // capture the command transaction
    if (accept) begin
      req_d = req_i;
    end

    case (op)
      gbn_pkg::OP_OFFER: begin
        strobe_d       = 1'b1;
        res_d.acked_to = ack_edge_q;
        res_d.freed    = '0;
        res_d.last     = 1'b1;
        if (offer_ok) begin
          res_d.kind    = gbn_pkg::KIND_SEND;
          res_d.seq_out = send_edge_q;
          res_d.len_out = req_q.seg_len;
          ram_we        = 1'b1;
          count_d       = count_q + CW'(1);
          send_edge_d   = send_edge_q + {{(SW - LW){1'b0}}, req_q.seg_len};
        end else begin
          res_d.kind    = gbn_pkg::KIND_REFUSED;
          res_d.seq_out = '0;
          res_d.len_out = '0;
        end
      end
      gbn_pkg::OP_ACK_SUB: begin
        dist_d = req_q.ack_num - ack_edge_q;
        span_d = send_edge_q - ack_edge_q;
      end
      gbn_pkg::OP_ACK_CHK: begin
        // oldest length fetched here for the free loop
        freed_d   = '0;
        ram_raddr = head_q;
        if (cond.ack_bad) begin
          strobe_d       = 1'b1;
          res_d.kind     = gbn_pkg::KIND_ACK_IGNORE;
          res_d.seq_out  = '0;
          res_d.len_out  = '0;
          res_d.acked_to = ack_edge_q;
          res_d.freed    = '0;
          res_d.last     = 1'b1;
        end
      end
      gbn_pkg::OP_ACK_FREE: begin
        if (cond.free_done) begin
          strobe_d       = 1'b1;
          res_d.kind     = gbn_pkg::KIND_ACK_OK;
          res_d.seq_out  = '0;
          res_d.len_out  = '0;
          res_d.acked_to = ack_edge_q;
          res_d.freed    = freed_wide[gbn_pkg::FREED_W-1:0];
          res_d.last     = 1'b1;
        end else begin
          // release the head segment and fetch the next one
          dist_d     = dist_q - rd_len;
          ack_edge_d = ack_edge_q + rd_len;
          head_d     = head_inc;
          count_d    = count_q - CW'(1);
          freed_d    = freed_q + CW'(1);
          ram_raddr  = head_inc;
        end
      end
      gbn_pkg::OP_TO_INIT: begin
        ptr_d     = head_q;
        iter_d    = count_q;
        seq_d     = ack_edge_q;
        ram_raddr = head_q;
      end
      gbn_pkg::OP_TO_EMIT: begin
        strobe_d       = 1'b1;
        res_d.kind     = gbn_pkg::KIND_RETX;
        res_d.seq_out  = seq_q;
        res_d.len_out  = ram_rdata;
        res_d.acked_to = ack_edge_q;
        res_d.freed    = '0;
        res_d.last     = cond.last_iter;
        seq_d          = seq_q + rd_len;
        iter_d         = iter_q - CW'(1);
        ptr_d          = ptr_inc;
        ram_raddr      = ptr_inc;
      end
      default: begin
      end
    endcase

    // configuration transaction, start sequence restarts the connection
    if (cfg_valid_i) begin
      case (cfg_index_i)
        gbn_pkg::CFG_WINDOW_BYTES: window_d = cfg_data_i[gbn_pkg::WIN_W-1:0];
        gbn_pkg::CFG_START_SEQ: begin
          start_seq_d = cfg_data_i;
          ack_edge_d  = cfg_data_i;
          send_edge_d = cfg_data_i;
          head_d      = '0;
          count_d     = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_edge_q  <= gbn_pkg::START_SEQ_RESET;
      send_edge_q <= gbn_pkg::START_SEQ_RESET;
      head_q      <= '0;
      count_q     <= '0;
      window_q    <= gbn_pkg::WINDOW_RESET;
      start_seq_q <= gbn_pkg::START_SEQ_RESET;
      strobe_q    <= 1'b0;
    end else begin
      ack_edge_q  <= ack_edge_d;
      send_edge_q <= send_edge_d;
      head_q      <= head_d;
      count_q     <= count_d;
      window_q    <= window_d;
      start_seq_q <= start_seq_d;
      strobe_q    <= strobe_d;
    end
  end

  // working and result payload, no reset needed
  always_ff @(posedge clk_i) begin
    dist_q  <= dist_d;
    span_q  <= span_d;
    ptr_q   <= ptr_d;
    iter_q  <= iter_d;
    seq_q   <= seq_d;
    freed_q <= freed_d;
    req_q   <= req_d;
    res_q   <= res_d;
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

// ----- src/gbn_chk.sv -----
module gbn_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           start_i,
  input logic                           busy_o,
  input gbn_pkg::in_t                   req_i,
  input logic                           res_strobe_o,
  input gbn_pkg::out_t                  res_o
);

  // an offer always answers with send or refused after its S_OFFER step
  a_offer_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_i.cmd == gbn_pkg::CMD_OFFER) |-> ##2
    (res_strobe_o && (res_o.kind == gbn_pkg::KIND_SEND ||
                      res_o.kind == gbn_pkg::KIND_REFUSED)))
    else $error("offer not answered in time");

  // only retransmits come in bursts, everything else is a single last result
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.kind != gbn_pkg::KIND_RETX) |-> res_o.last)
    else $error("non-retransmit result without last");

  // a retransmit burst runs on consecutive cycles until its last result
  a_retx_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.kind == gbn_pkg::KIND_RETX && !res_o.last) |=>
    (res_strobe_o && res_o.kind == gbn_pkg::KIND_RETX))
    else $error("retransmit burst broken");

  // freed segments are reported only on an accepted ack
  a_freed_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.freed != '0) |-> (res_o.kind == gbn_pkg::KIND_ACK_OK))
    else $error("freed count on wrong result kind");

endmodule

bind go_back_n_sender_window_core gbn_chk u_gbn_chk (.*);
